[hw/rtl/wheel_speed_ratio_balancer_macros.svh]
// ----------------------------------------------------------------------------
// Wheel speed ratio balancer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_RATIO_BALANCER_MACROS_SVH
`define WHEEL_SPEED_RATIO_BALANCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wsrb_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel speed ratio balancer package
// Widths, codes and the sequencer state type shared by the block's files.
// ----------------------------------------------------------------------------
package wsrb_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TARGET_W    = 16;
  localparam int SPEED_W     = 8;
  localparam int FRAC_BITS   = 12;
  localparam int CMD_W       = 2;
  localparam int MODE_W      = 2;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  // Product of target and right count, and the widest dividend.
  localparam int TR_W  = TARGET_W + COUNT_WIDTH;
  localparam int REM_W = TR_W + SPEED_W;
  // Tolerance compare: 1000 * t * R plus 4096 * R fits in this width.
  localparam int CMP_W = TR_W + 11;

  localparam int QUO_W  = 8;
  localparam int STEP_W = 4;

  // The 0.001 tolerance is applied as 1000 * (L / R) against 1000 * T.
  localparam int TOL_INV   = 1000;
  localparam int LHS_SCALE = TOL_INV * (1 << FRAC_BITS);
  localparam int QUO_LIMIT = 254;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1 << FRAC_BITS);

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [MODE_W-1:0] mode_t;

  localparam cmd_t CMD_LEFT  = 2'd0;
  localparam cmd_t CMD_RIGHT = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  localparam mode_t MODE_OFF    = 2'd0;
  localparam mode_t MODE_REMARK = 2'd1;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/wsrb_if.sv]
// ----------------------------------------------------------------------------
// Wheel speed ratio balancer channels
// Valid/ready channels for encoder events and corrected speed results.
// ----------------------------------------------------------------------------
interface wsrb_in_if;
  import wsrb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [SPEED_W-1:0]   left_speed;
  logic [SPEED_W-1:0]   right_speed;

  modport source (output valid, cmd, left_speed, right_speed, input ready);
  modport sink   (input valid, cmd, left_speed, right_speed, output ready);
endinterface

interface wsrb_out_if;
  import wsrb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SPEED_W-1:0]   new_left_speed;
  logic [SPEED_W-1:0]   new_right_speed;

  modport source (output valid, new_left_speed, new_right_speed, input ready);
  modport sink   (input valid, new_left_speed, new_right_speed, output ready);
endinterface

[hw/rtl/wheel_speed_ratio_balancer.sv]
// Sequencing: a pulse, or a tick with the mode off, is handled in idle; a tick with a zero
// count or speed leaves from MUL1, and one inside the tolerance band from CMP. A correcting
// tick runs MUL1, MUL2, CMP, one or two divider passes and DONE (a first pass stops at its
// top step once its quotient hits 256). A new tick is taken only back in idle, so input
// also waits while the output register holds an untaken result.
// Reset: synchronous, active low; clears counts, marks and output valid, target 1.0, mode off.
// ----------------------------------------------------------------------------
// Wheel speed ratio balancer
// Compares left/right encoder pulse ratio with a target on each control tick
// and corrects one wheel speed command through a shared iterative divider.
// ----------------------------------------------------------------------------
`include "wheel_speed_ratio_balancer_macros.svh"

module wheel_speed_ratio_balancer (
  input  logic                         clk,
  input  logic                         rst_n,
  wsrb_in_if.sink                      in_chan,
  wsrb_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsrb_pkg::ADDR_W-1:0]  paddr,
  input  logic [wsrb_pkg::DATA_W-1:0]  pwdata,
  output logic [wsrb_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import wsrb_pkg::*;

  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(QUO_W);

  // Configuration registers.
  logic [TARGET_W-1:0]    target_r, target_nxt;
  mode_t                  mode_r, mode_nxt;

  // Pulse counters and window marks.
  logic [COUNT_WIDTH-1:0] left_count_r, left_count_nxt;
  logic [COUNT_WIDTH-1:0] right_count_r, right_count_nxt;
  logic [COUNT_WIDTH-1:0] left_mark_r, left_mark_nxt;
  logic [COUNT_WIDTH-1:0] right_mark_r, right_mark_nxt;

  // Sequencer.
  state_t                 state_r, state_nxt;

  // Operands captured from the tick transaction.
  logic [COUNT_WIDTH-1:0] l_r, l_nxt;
  logic [COUNT_WIDTH-1:0] r_r, r_nxt;
  logic [SPEED_W-1:0]     ls_r, ls_nxt;
  logic [SPEED_W-1:0]     rs_r, rs_nxt;
  logic [TARGET_W-1:0]    t_r, t_nxt;

  // Products.
  logic [TR_W-1:0]                trp_r, trp_nxt;
  logic [COUNT_WIDTH+SPEED_W-1:0] lrs_r, lrs_nxt;
  logic [REM_W-1:0]               num_a_r, num_a_nxt;
  logic [CMP_W-1:0]               lhs_r, lhs_nxt;
  logic [CMP_W-1:0]               tr_r, tr_nxt;

  // Shared restoring divider.
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [TR_W-1:0]        den_r, den_nxt;
  logic [QUO_W-1:0]       q_r, q_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   div_a_r, div_a_nxt;
  logic                   final_r, final_nxt;

  // Result staging and the output register.
  logic [SPEED_W-1:0]     nl_r, nl_nxt;
  logic [SPEED_W-1:0]     nr_r, nr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]     out_left_r, out_left_nxt;
  logic [SPEED_W-1:0]     out_right_r, out_right_nxt;

  // Combinational helpers.
  logic                   in_ready;
  logic                   in_acc;
  logic                   cfg_wr;
  logic [REM_W-1:0]       den_sh;
  logic                   ge;
  logic [REM_W-1:0]       rem_sub;
  logic [QUO_W-1:0]       q_cur;
  logic                   fin;
  logic [QUO_W-1:0]       fin_q;
  logic                   fin_over;
  logic [CMP_W-1:0]       tol;
  logic [REM_W-1:0]       num_b;
  logic [TR_W-1:0]        den_a;

  // The input side only opens between ticks; a pulse is counted as it is accepted.
  assign in_ready      = (state_r == ST_IDLE);
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.new_left_speed  = out_left_r;
  assign out_chan.new_right_speed = out_right_r;

  // APB-style register port, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_TARGET: prdata = DATA_W'(target_r);
      REG_MODE:   prdata = DATA_W'(mode_r);
      default:    prdata = '0;
    endcase
  end

  // One divider step: try to take den << step from the remainder. The top
  // step only checks whether the quotient reaches 256, which saturates.
  assign den_sh  = REM_W'(den_r) << step_r;
  assign ge      = (rem_r >= den_sh);
  assign rem_sub = rem_r - den_sh;
  assign q_cur   = ge ? (q_r | (QUO_W'(1) << step_r[2:0])) : q_r;

  // Tolerance term 4096 * R, and the operands of the two quotients:
  // A = t*R*ls / (4096*L) and B = 4096*L*rs / (t*R).
  assign tol   = CMP_W'(r_r) << FRAC_BITS;
  assign num_b = REM_W'(lrs_r) << FRAC_BITS;
  assign den_a = TR_W'(l_r) << FRAC_BITS;

  always_comb begin
    target_nxt      = target_r;
    mode_nxt        = mode_r;
    left_count_nxt  = left_count_r;
    right_count_nxt = right_count_r;
    left_mark_nxt   = left_mark_r;
    right_mark_nxt  = right_mark_r;
    state_nxt       = state_r;
    l_nxt           = l_r;
    r_nxt           = r_r;
    ls_nxt          = ls_r;
    rs_nxt          = rs_r;
    t_nxt           = t_r;
    trp_nxt         = trp_r;
    lrs_nxt         = lrs_r;
    num_a_nxt       = num_a_r;
    lhs_nxt         = lhs_r;
    tr_nxt          = tr_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    q_nxt           = q_r;
    step_nxt        = step_r;
    div_a_nxt       = div_a_r;
    final_nxt       = final_r;
    nl_nxt          = nl_r;
    nr_nxt          = nr_r;
    out_valid_nxt   = out_valid_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;
    fin             = 1'b0;
    fin_q           = q_cur;
    fin_over        = 1'b0;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_TARGET: target_nxt = pwdata[TARGET_W-1:0];
        REG_MODE:   mode_nxt   = pwdata[MODE_W-1:0];
        default:    ;
      endcase
    end

    // The output slot empties when its transaction completes.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.cmd)
            CMD_LEFT:  left_count_nxt  = left_count_r + 1'b1;
            CMD_RIGHT: right_count_nxt = right_count_r + 1'b1;
            CMD_TICK: begin
              if (mode_r != MODE_OFF) begin
                l_nxt  = left_count_r - left_mark_r;
                r_nxt  = right_count_r - right_mark_r;
                ls_nxt = in_chan.left_speed;
                rs_nxt = in_chan.right_speed;
                t_nxt  = target_r;
                if (mode_r == MODE_REMARK) begin
                  left_mark_nxt  = left_count_r;
                  right_mark_nxt = right_count_r;
                end
                state_nxt = ST_MUL1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MUL1: begin
        if (l_r == '0 || r_r == '0 || ls_r == '0 || rs_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          trp_nxt   = TR_W'(t_r) * TR_W'(r_r);
          lrs_nxt   = (COUNT_WIDTH+SPEED_W)'(l_r) * (COUNT_WIDTH+SPEED_W)'(rs_r);
          lhs_nxt   = CMP_W'(l_r) * CMP_W'(LHS_SCALE);
          state_nxt = ST_MUL2;
        end
      end

      ST_MUL2: begin
        num_a_nxt = REM_W'(trp_r) * REM_W'(ls_r);
        tr_nxt    = CMP_W'(trp_r) * CMP_W'(TOL_INV);
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        step_nxt = STEP_TOP;
        q_nxt    = '0;
        if (lhs_r + tol < tr_r) begin
          // Left is slow: try raising the left speed first.
          rem_nxt   = num_a_r;
          den_nxt   = den_a;
          div_a_nxt = 1'b1;
          final_nxt = 1'b0;
          state_nxt = ST_DIV;
        end else if (lhs_r > tr_r + tol) begin
          state_nxt = ST_DIV;
          if (t_r == '0) begin
            // A zero target leaves no right quotient; go straight to the left.
            rem_nxt   = num_a_r;
            den_nxt   = den_a;
            div_a_nxt = 1'b1;
            final_nxt = 1'b1;
          end else begin
            rem_nxt   = num_b;
            den_nxt   = trp_r;
            div_a_nxt = 1'b0;
            final_nxt = 1'b0;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DIV: begin
        if (step_r == STEP_TOP) begin
          if (ge) begin
            fin      = 1'b1;
            fin_q    = '1;
            fin_over = 1'b1;
          end else begin
            step_nxt = step_r - 1'b1;
          end
        end else begin
          rem_nxt = ge ? rem_sub : rem_r;
          q_nxt   = q_cur;
          if (step_r == '0) begin
            fin      = 1'b1;
            fin_q    = q_cur;
            fin_over = (q_cur > QUO_W'(QUO_LIMIT));
          end else begin
            step_nxt = step_r - 1'b1;
          end
        end

        if (fin) begin
          if (!final_r && fin_over) begin
            // First quotient too large: correct the other wheel instead.
            final_nxt = 1'b1;
            div_a_nxt = !div_a_r;
            step_nxt  = STEP_TOP;
            q_nxt     = '0;
            if (div_a_r) begin
              rem_nxt = num_b;
              den_nxt = trp_r;
            end else begin
              rem_nxt = num_a_r;
              den_nxt = den_a;
            end
          end else begin
            if (div_a_r) begin
              nl_nxt = fin_q;
              nr_nxt = rs_r;
            end else begin
              nl_nxt = ls_r;
              nr_nxt = fin_q;
            end
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = nl_r;
          out_right_nxt = nr_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      target_r      <= TARGET_RESET;
      mode_r        <= MODE_OFF;
      left_count_r  <= '0;
      right_count_r <= '0;
      left_mark_r   <= '0;
      right_mark_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      target_r      <= target_nxt;
      mode_r        <= mode_nxt;
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
      left_mark_r   <= left_mark_nxt;
      right_mark_r  <= right_mark_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers, qualified by the sequencer.
  always_ff @(posedge clk) begin
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    ls_r        <= ls_nxt;
    rs_r        <= rs_nxt;
    t_r         <= t_nxt;
    trp_r       <= trp_nxt;
    lrs_r       <= lrs_nxt;
    num_a_r     <= num_a_nxt;
    lhs_r       <= lhs_nxt;
    tr_r        <= tr_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    q_r         <= q_nxt;
    step_r      <= step_nxt;
    div_a_r     <= div_a_nxt;
    final_r     <= final_nxt;
    nl_r        <= nl_nxt;
    nr_r        <= nr_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  // The divider step index never leaves its range while dividing.
  `WSRB_ASSERT_SAME(a_step_range, state_r == ST_DIV, step_r <= STEP_TOP, "divider step out of range")

  // A left pulse transaction advances the left counter by exactly one.
  `WSRB_ASSERT_NEXT(a_left_pulse, in_acc && in_chan.cmd == CMD_LEFT, left_count_r == $past(left_count_r) + 1'b1, "left count did not advance")

  // A result is only ever offered out of the result hand-off state.
  `WSRB_ASSERT_SAME(a_out_source, $rose(out_valid_r), $past(state_r == ST_DONE), "result offered outside hand-off")

endmodule
